>>> hw/rtl/ct97_pkg.sv
// Shared constants, types and register codes of the 9x7 census transform.
package ct97_pkg;

    localparam int PIXEL_W           = 8;
    localparam int WIN_ROWS          = 7;
    localparam int WIN_COLS          = 9;
    localparam int HALF_ROWS         = WIN_ROWS / 2;
    localparam int HALF_COLS         = WIN_COLS / 2;
    localparam int STORE_LINES       = WIN_ROWS - 1;
    localparam int WORD_W            = WIN_ROWS * WIN_COLS - 1;
    localparam int ROW_W             = 12;
    localparam int CCOL_W            = 10;
    localparam int WIDTH_REG_W       = 11;
    localparam int HEIGHT_REG_W      = 12;
    localparam int CFG_DATA_W        = 12;
    localparam int CFG_INDEX_W       = 1;
    localparam int WIDTH_RESET       = 640;
    localparam int HEIGHT_RESET      = 480;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MIN_WIDTH         = WIN_COLS;
    localparam int MIN_HEIGHT        = WIN_ROWS;
    localparam int MAX_HEIGHT        = 4095;
    localparam int QUEUE_DEPTH       = 2;
    localparam int IN_DATA_W         = 8;
    localparam int OUT_DATA_W        = 88;
    localparam int OUT_PAD_W         = OUT_DATA_W - WORD_W - ROW_W - CCOL_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [STORE_LINES-1:0][PIXEL_W-1:0] line_col_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        line_col_t          lines;
        logic               word_valid;
        logic               inner;
        logic [ROW_W-1:0]   centre_row;
        logic [CCOL_W-1:0]  centre_col;
    } ct97_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ct97_qstat_t;

endpackage

>>> hw/rtl/ct97_front.sv
// Front end: configuration, raster position, classification and line stores.
module ct97_front #(
    parameter int MAX_WIDTH = ct97_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ct97_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ct97_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ct97_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  ct97_pkg::ct97_qstat_t               qstat,
    output logic                                push,
    output ct97_pkg::ct97_item_t                push_item
);
    import ct97_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CW-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;

    logic                    f1_valid_reg, f1_valid_next;
    logic [PIXEL_W-1:0]      f1_px_reg;
    logic [CW-1:0]           f1_col_reg;
    logic                    f1_word_valid_reg;
    logic                    f1_inner_reg;
    logic [ROW_W-1:0]        f1_row_reg;
    logic [CCOL_W-1:0]       f1_ccol_reg;
    line_col_t               rd_data_reg;
    line_col_t               line_mem [MAX_WIDTH];

    logic [EW-1:0]           w_ext;
    logic [EW-1:0]           w_sat;
    logic [WW-1:0]           w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic [WW-1:0]           col_wide;
    logic                    accept;
    logic                    cls_valid;
    logic                    cls_inner;
    logic [CW-1:0]           cc_full;

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(MIN_WIDTH))
        begin
            w_sat = EW'(MIN_WIDTH);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_sat = EW'(MAX_WIDTH);
        end
        else
        begin
            w_sat = w_ext;
        end
        w_eff = WW'(w_sat);
        h_eff = (height_reg < HEIGHT_REG_W'(MIN_HEIGHT)) ? HEIGHT_REG_W'(MIN_HEIGHT) :
                height_reg;
    end

    assign col_wide      = WW'(col_reg);
    assign s_axis_tready = !f1_valid_reg || !qstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = f1_valid_reg && !qstat.full;

    always_comb
    begin
        cls_valid = (row_reg >= ROW_W'(HALF_ROWS)) && (col_reg >= CW'(HALF_COLS));
        cls_inner = cls_valid && (row_reg >= ROW_W'(2 * HALF_ROWS)) && (row_reg < h_eff) &&
                    (col_reg >= CW'(2 * HALF_COLS)) && (col_wide < w_eff);
        cc_full   = col_reg - CW'(HALF_COLS);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if ((col_wide + WW'(1)) >= w_eff)
            begin
                col_next = '0;
                row_next = ({1'b0, row_reg} + (ROW_W + 1)'(1) >= {1'b0, h_eff}) ? '0 :
                           row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
        begin
            f1_valid_next = 1'b1;
        end
        else if (push)
        begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_REG_W'(WIDTH_RESET);
            height_reg   <= HEIGHT_REG_W'(HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_px_reg         <= s_axis_tdata[PIXEL_W-1:0];
            f1_col_reg        <= col_reg;
            f1_word_valid_reg <= cls_valid;
            f1_inner_reg      <= cls_inner;
            f1_row_reg        <= cls_valid ? (row_reg - ROW_W'(HALF_ROWS)) : '0;
            f1_ccol_reg       <= cls_valid ? CCOL_W'(cc_full) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (push)
        begin
            line_mem[f1_col_reg] <= {rd_data_reg[STORE_LINES-2:0], f1_px_reg};
        end
    end

    always_comb
    begin
        push_item.px         = f1_px_reg;
        push_item.lines      = rd_data_reg;
        push_item.word_valid = f1_word_valid_reg;
        push_item.inner      = f1_inner_reg;
        push_item.centre_row = f1_row_reg;
        push_item.centre_col = f1_ccol_reg;
    end

endmodule

>>> hw/rtl/ct97_queue.sv
// Short queue that decouples the front end from the window and census back end.
module ct97_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ct97_pkg::ct97_item_t  push_item,
    input  logic                  pop,
    output ct97_pkg::ct97_item_t  pop_item,
    output ct97_pkg::ct97_qstat_t qstat
);
    import ct97_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    ct97_item_t    slots [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item    = slots[rd_ptr_reg];
    assign qstat.full  = (count_reg == NW'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

>>> hw/rtl/ct97_back.sv
// Back end: 7x9 pixel window, census comparison and output register.
module ct97_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ct97_pkg::ct97_qstat_t               qstat,
    input  ct97_pkg::ct97_item_t                pop_item,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ct97_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser
);
    import ct97_pkg::*;

    typedef logic [WIN_ROWS-1:0][WIN_COLS-1:0][PIXEL_W-1:0] window_t;

    window_t            win_reg, win_next;
    logic               b1_valid_reg, b1_valid_next;
    logic               b1_word_valid_reg;
    logic               b1_inner_reg;
    logic [ROW_W-1:0]   b1_row_reg;
    logic [CCOL_W-1:0]  b1_ccol_reg;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               out_flag_reg;
    logic               b1_adv;
    logic [WORD_W-1:0]  census;

    function automatic logic [WORD_W-1:0] census_of(input window_t w);
        logic [WORD_W-1:0]  word;
        logic [PIXEL_W-1:0] centre;
        int                 b;
        word   = '0;
        centre = w[HALF_ROWS][HALF_COLS];
        b      = WORD_W - 1;
        for (int x = 0; x < WIN_ROWS; x++)
        begin
            for (int y = 0; y < WIN_COLS; y++)
            begin
                if (!(x == HALF_ROWS && y == HALF_COLS))
                begin
                    word[b] = (centre > w[x][y]);
                    b       = b - 1;
                end
            end
        end
        return word;
    endfunction

    assign b1_adv = b1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign pop    = !qstat.empty && (!b1_valid_reg || b1_adv);
    assign census = census_of(win_reg);

    always_comb
    begin
        win_next = win_reg;
        if (pop)
        begin
            for (int k = 0; k < WIN_ROWS; k++)
            begin
                for (int j = 0; j < WIN_COLS - 1; j++)
                begin
                    win_next[k][j] = win_reg[k][j + 1];
                end
            end
            for (int k = 0; k < STORE_LINES; k++)
            begin
                win_next[k][WIN_COLS - 1] = pop_item.lines[STORE_LINES - 1 - k];
            end
            win_next[WIN_ROWS - 1][WIN_COLS - 1] = pop_item.px;
        end
    end

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (pop)
        begin
            b1_valid_next = 1'b1;
        end
        else if (b1_adv)
        begin
            b1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (b1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_word_valid_reg <= pop_item.word_valid;
            b1_inner_reg      <= pop_item.inner;
            b1_row_reg        <= pop_item.centre_row;
            b1_ccol_reg       <= pop_item.centre_col;
        end
        if (b1_adv)
        begin
            out_data_reg <= {OUT_PAD_W'(0), b1_ccol_reg, b1_row_reg,
                             b1_inner_reg ? census : WORD_W'(0)};
            out_flag_reg <= b1_word_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

endmodule

>>> hw/rtl/census_transform_9x7_top.sv
// Top level of the streaming 9x7 census transform.
//
//  Channel   Dir  Signals                               Content
//  s_axis    in   tvalid tready tdata[7:0]             pixel
//  m_axis    out  tvalid tready tdata[87:0] tuser      census word, centre row and column, flag
//  cfg       in   cfg_we cfg_index[0:0] cfg_wdata[11:0] image width, image height
//
//  One pixel is accepted and one result delivered per cycle while m_axis_tready stays high;
//  each pixel passes through the line store read, the queue, the window stage and the output register.
//  Reset clears the raster position, the window and the handshakes, and loads width 640
//  and height 480; the line store is not cleared and needs no clearing pass.
//  A stalled output holds in its register; the two-entry queue absorbs the front end
//  until it fills, after which s_axis_tready falls.
module census_transform_9x7_top #(
    parameter int MAX_WIDTH = ct97_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ct97_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ct97_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: pixel[7:0].
    input  logic [ct97_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: census_word[61:0], centre_row[73:62], centre_col[83:74], zeros.
    output logic [ct97_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: word_valid.
    output logic                                m_axis_tuser
);
    import ct97_pkg::*;

    ct97_qstat_t qstat;
    ct97_item_t  push_item;
    ct97_item_t  pop_item;
    logic        push;
    logic        pop;

    ct97_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    ct97_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    ct97_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> hw/rtl/ct97_checker.sv
// Port-level checks on the census transform output channel, bound to the top level.
module ct97_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ct97_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);
    import ct97_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("Output transfer offered during reset.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled output changed.");

    a_no_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("Result without a completed centre carries data.");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tdata[73:62] < 12'(HALF_ROWS)) ||
                          (m_axis_tdata[83:74] < 10'(HALF_COLS)))
            |-> m_axis_tdata[61:0] == '0)
        else $error("Border centre gave a nonzero census word.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[87:84] == '0)
        else $error("Padding bits of the output are not zero.");

endmodule

bind census_transform_9x7_top ct97_checker u_ct97_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
